FILE: rtl/slq_pkg.sv
// Shared types and constants for the sorted list engine.
// No dependencies; every other file imports this package.
package slq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 5;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [1:0] {
    OP_ORD_INS = 2'd0,
    OP_IDX_INS = 2'd1,
    OP_IDX_DEL = 2'd2,
    OP_VAL_DEL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t                op;
    logic               we;
    value_t             val;
    logic [POS_W-1:0]   pos;
  } ctl_t;

endpackage

FILE: rtl/slq_if.sv
// Valid/ready channel interfaces for command and result words.
// Depends on slq_pkg for the field widths.
interface slq_cmd_if import slq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  value_t             value;
  logic [POS_W-1:0]   position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface slq_res_if import slq_pkg::*; ();
  logic         valid;
  logic         ready;
  logic [1:0]   status;
  value_t       removed_value;
  logic         empty_res;

  modport source (output valid, status, removed_value, empty_res, input ready);
  modport sink   (input valid, status, removed_value, empty_res, output ready);
endinterface

FILE: rtl/slq_cell.sv
// One list slot: holds an entry, finds its own hit and shifts with its neighbors.
// Depends on slq_pkg.
module slq_cell import slq_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  ctl_t    ctl,
  input  logic    vld,
  input  value_t  left,
  input  value_t  right,
  input  logic    hit_in,
  input  value_t  carry_in,
  output value_t  value,
  output logic    hit_out,
  output value_t  carry_out
);

  logic my_hit;
  logic at_pos;

  assign at_pos = (32'(ctl.pos) == 32'(IDX));

  always_comb begin
    unique case (ctl.op)
      OP_ORD_INS: my_hit = !vld || !(value < ctl.val);
      OP_IDX_INS: my_hit = at_pos;
      OP_IDX_DEL: my_hit = at_pos;
      OP_VAL_DEL: my_hit = vld && (value == ctl.val);
      default:    my_hit = 1'b0;
    endcase
  end

  assign hit_out   = hit_in || my_hit;
  assign carry_out = (my_hit && !hit_in) ? value : carry_in;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      if (ctl.op == OP_ORD_INS || ctl.op == OP_IDX_INS) begin
        if (hit_in) begin
          value <= left;
        end else if (my_hit) begin
          value <= ctl.val;
        end
      end else if (hit_out) begin
        value <= right;
      end
    end
  end

endmodule

FILE: rtl/sorted_list_engine_top.sv
// Sorted list engine top: row of list cells, entry count and result register.
// Depends on slq_pkg, slq_if and slq_cell.
//
//   channel  dir  fields
//   cmd      in   command, value, position
//   res      out  status, removed_value, empty_res
//
// One command per cycle while results are taken; its result word is registered and shows in the next cycle.
// The hit chain through the row of cells sets the critical path.
// Reset empties the list at once; entries need no clearing.
// A stalled result holds the command side until it is taken.
module sorted_list_engine_top import slq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  slq_cmd_if.sink      cmd,
  slq_res_if.source    res
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            accept;
  logic            full;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  status_t         st;
  ctl_t            ctl;
  value_t          vals  [DEPTH];
  logic            vld   [DEPTH];
  logic            hit   [DEPTH+1];
  value_t          carry [DEPTH+1];

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == CW'(DEPTH));
  assign pos_x     = CMPW'(cmd.position);
  assign cnt_x     = CMPW'(count);

  assign hit[0]   = 1'b0;
  assign carry[0] = '1;

  always_comb begin
    unique case (op_t'(cmd.command))
      OP_ORD_INS: st = full ? ST_FULL : ST_OK;
      OP_IDX_INS: st = full ? ST_FULL : ((pos_x > cnt_x) ? ST_RANGE : ST_OK);
      OP_IDX_DEL: st = (pos_x >= cnt_x) ? ST_RANGE : ST_OK;
      OP_VAL_DEL: st = hit[DEPTH] ? ST_OK : ST_NOTFOUND;
      default:    st = ST_OK;
    endcase
  end

  always_comb begin
    ctl.op  = op_t'(cmd.command);
    ctl.we  = accept && (st == ST_OK);
    ctl.val = cmd.value;
    ctl.pos = cmd.position;
  end

  always_comb begin
    count_next = count;
    if (ctl.we) begin
      if (ctl.op == OP_ORD_INS || ctl.op == OP_IDX_INS) begin
        count_next = count + CW'(1);
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign vld[i] = (count > CW'(i));

    slq_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .vld       (vld[i]),
      .left      ((i == 0) ? cmd.value : vals[(i == 0) ? 0 : i - 1]),
      .right     ((i == DEPTH - 1) ? vals[i] : vals[(i == DEPTH - 1) ? i : i + 1]),
      .hit_in    (hit[i]),
      .carry_in  (carry[i]),
      .value     (vals[i]),
      .hit_out   (hit[i+1]),
      .carry_out (carry[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.status        <= st;
      res.removed_value <= (ctl.op == OP_IDX_DEL && st == ST_OK) ? carry[DEPTH] : '1;
      res.empty_res     <= (count_next == '0);
    end
  end

endmodule
